// ===== rtl/xmodem_block_sender_core_macros.svh =====
// Assertion macros used by the checker file of the XMODEM block sender.
`ifndef XMODEM_BLOCK_SENDER_CORE_MACROS_SVH
`define XMODEM_BLOCK_SENDER_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define XBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define XBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/xbs_pkg.sv =====
`default_nettype none
package xbs_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int ADDR_W      = $clog2(BLOCK_BYTES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int IDX_W       = 8;
  localparam int BYTE_W      = 8;
  localparam int CMD_W       = 2;
  localparam int LIMIT_W     = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [CNT_W-1:0]   FILL_FULL    = CNT_W'(BLOCK_BYTES);
  localparam logic [IDX_W-1:0]   IDX_DATA0    = IDX_W'(3);
  localparam logic [IDX_W-1:0]   IDX_CHECK_HI = IDX_W'(BLOCK_BYTES + 3);
  localparam logic [IDX_W-1:0]   IDX_CHECK_LO = IDX_W'(BLOCK_BYTES + 4);
  localparam logic [QCNT_W-1:0]  QFULL        = QCNT_W'(QDEPTH);

  localparam logic [15:0]        CRC_POLY     = 16'h1021;

  localparam logic [BYTE_W-1:0]  SYM_SOH      = 8'h01;
  localparam logic [BYTE_W-1:0]  SYM_EOT      = 8'h04;
  localparam logic [BYTE_W-1:0]  SYM_ACK      = 8'h06;
  localparam logic [BYTE_W-1:0]  SYM_NAK      = 8'h15;
  localparam logic [BYTE_W-1:0]  SYM_CAN      = 8'h18;
  localparam logic [BYTE_W-1:0]  SYM_CRC_REQ  = 8'h43;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 4'd6;
  localparam logic [BYTE_W-1:0]  PAD_RESET    = 8'd26;
  localparam logic [BYTE_W-1:0]  BLKNUM_RESET = 8'd1;

  localparam logic [CFG_IDX_W-1:0] REG_HANDSHAKE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_VALUE       = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SOURCE  = 2'd0,
    CMD_END     = 2'd1,
    CMD_RECEIVE = 2'd2,
    CMD_SLOT    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_HANDSHAKE = 3'd0,
    ST_LOADING   = 3'd1,
    ST_SENDING   = 3'd2,
    ST_AWAIT     = 3'd3,
    ST_DONE      = 3'd4,
    ST_FAILED    = 3'd5
  } status_t;

  typedef enum logic [7:0] {
    PH_HANDSHAKE = 8'b0000_0001,
    PH_LOADING   = 8'b0000_0010,
    PH_SENDING   = 8'b0000_0100,
    PH_AWAIT     = 8'b0000_1000,
    PH_EOT_SEND  = 8'b0001_0000,
    PH_EOT_WAIT  = 8'b0010_0000,
    PH_DONE      = 8'b0100_0000,
    PH_FAILED    = 8'b1000_0000
  } phase_t;

  // One classified item as it sits in the queue between front and back.
  typedef struct packed {
    cmd_t              cmd;
    logic [BYTE_W-1:0] value;
    logic              is_crc_req;
    logic              is_nak;
    logic              is_ack;
    logic              is_can;
  } item_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              ready_for_data;
    status_t           status;
  } result_t;

  // CRC-16, polynomial 0x1021, MSB first, one byte per call.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [BYTE_W-1:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/xbs_channels.sv =====
`default_nettype none
interface xbs_in_if import xbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] value;

  modport source(output valid, output command, output value, input ready);
  modport sink(input valid, input command, input value, output ready);
endinterface

interface xbs_out_if import xbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              tx_valid;
  logic [BYTE_W-1:0] tx_byte;
  logic              ready_for_data;
  logic [2:0]        status;

  modport source(output valid, output tx_valid, output tx_byte, output ready_for_data,
                 output status, input ready);
  modport sink(input valid, input tx_valid, input tx_byte, input ready_for_data,
               input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/xbs_ram.sv =====
`default_nettype none
module xbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/xbs_front.sv =====
`default_nettype none
module xbs_front import xbs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  xbs_in_if.sink    items,
  input  wire logic pop,
  output head_t     head
);

  item_t              q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               do_pop;
  item_t              incoming;

  // Classify the item once on entry so the back end only sees flags.
  always_comb begin
    incoming.cmd        = cmd_t'(items.command);
    incoming.value      = items.value;
    incoming.is_crc_req = (items.value == SYM_CRC_REQ);
    incoming.is_nak     = (items.value == SYM_NAK);
    incoming.is_ack     = (items.value == SYM_ACK);
    incoming.is_can     = (items.value == SYM_CAN);
  end

  assign items.ready = (count != QFULL);
  assign push        = items.valid && items.ready;
  assign do_pop      = pop && (count != '0);

  assign head.valid  = (count != '0);
  assign head.item   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/xbs_back.sv =====
`default_nettype none
module xbs_back import xbs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire head_t head,
  output logic       pop,
  xbs_out_if.source  results
);

  phase_t             phase, phase_next;
  logic               crc_mode, crc_mode_next;
  logic [BYTE_W-1:0]  block_number, block_number_next;
  logic [CNT_W-1:0]   fill_count, fill_count_next;
  logic [IDX_W-1:0]   send_index, send_index_next;
  logic [15:0]        crc_acc, crc_acc_next;
  logic [BYTE_W-1:0]  sum_acc, sum_acc_next;
  logic [LIMIT_W-1:0] tries_seen, tries_seen_next;
  logic               source_ended, source_ended_next;
  logic [LIMIT_W-1:0] handshake_limit;
  logic [BYTE_W-1:0]  pad_value;

  logic               out_valid;
  result_t            out_res;
  result_t            res_next;

  logic               ram_we;
  logic [BYTE_W-1:0]  ram_rdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [IDX_W-1:0]   data_pos;
  logic [IDX_W-1:0]   last_index;
  logic [BYTE_W-1:0]  data_byte;
  logic               accepting;
  logic               accepting_next;

  // The buffer is read ahead: the address follows the next send index so
  // the registered data lines up with the byte due at the next slot.
  assign data_pos  = send_index_next - IDX_DATA0;
  assign ram_raddr = data_pos[ADDR_W-1:0];

  xbs_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(BLOCK_BYTES)
  ) u_buffer (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_count[ADDR_W-1:0]),
    .wdata (head.item.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pop = head.valid && (!out_valid || results.ready);

  assign accepting = ((phase == PH_HANDSHAKE) || (phase == PH_LOADING)) &&
                     (fill_count < FILL_FULL) && !source_ended;

  assign last_index = crc_mode ? IDX_CHECK_LO : IDX_CHECK_HI;
  assign data_byte  = ((send_index - IDX_DATA0) < IDX_W'(fill_count)) ? ram_rdata : pad_value;

  always_comb begin
    phase_next        = phase;
    crc_mode_next     = crc_mode;
    block_number_next = block_number;
    fill_count_next   = fill_count;
    send_index_next   = send_index;
    crc_acc_next      = crc_acc;
    sum_acc_next      = sum_acc;
    tries_seen_next   = tries_seen;
    source_ended_next = source_ended;
    ram_we            = 1'b0;
    res_next.tx_valid = 1'b0;
    res_next.tx_byte  = '0;

    if (pop) begin
      unique case (head.item.cmd)
        CMD_SOURCE: begin
          if (accepting) begin
            ram_we          = 1'b1;
            fill_count_next = fill_count + 1'b1;
            if ((phase == PH_LOADING) && (fill_count_next >= FILL_FULL)) begin
              send_index_next = '0;
              crc_acc_next    = '0;
              sum_acc_next    = '0;
              phase_next      = PH_SENDING;
            end
          end
        end
        CMD_END: begin
          if (!source_ended) begin
            source_ended_next = 1'b1;
            if (phase == PH_LOADING) begin
              if (fill_count != '0) begin
                send_index_next = '0;
                crc_acc_next    = '0;
                sum_acc_next    = '0;
                phase_next      = PH_SENDING;
              end else begin
                phase_next = PH_EOT_SEND;
              end
            end
          end
        end
        CMD_RECEIVE: begin
          if (phase == PH_HANDSHAKE) begin
            if (head.item.is_crc_req || head.item.is_nak) begin
              crc_mode_next = head.item.is_crc_req;
              // Pick up whatever the source has already buffered.
              if ((fill_count >= FILL_FULL) || (source_ended && (fill_count != '0))) begin
                send_index_next = '0;
                crc_acc_next    = '0;
                sum_acc_next    = '0;
                phase_next      = PH_SENDING;
              end else if (source_ended) begin
                phase_next = PH_EOT_SEND;
              end else begin
                phase_next = PH_LOADING;
              end
            end else begin
              tries_seen_next = tries_seen + 1'b1;
              if (tries_seen_next >= handshake_limit) begin
                phase_next = PH_FAILED;
              end
            end
          end else if (phase == PH_AWAIT) begin
            if (head.item.is_ack) begin
              block_number_next = block_number + 1'b1;
              fill_count_next   = '0;
              phase_next        = source_ended ? PH_EOT_SEND : PH_LOADING;
            end else if (head.item.is_nak) begin
              send_index_next = '0;
              crc_acc_next    = '0;
              sum_acc_next    = '0;
              phase_next      = PH_SENDING;
            end else if (head.item.is_can) begin
              phase_next = PH_FAILED;
            end
          end else if (phase == PH_EOT_WAIT) begin
            phase_next = head.item.is_ack ? PH_DONE : PH_EOT_SEND;
          end
        end
        CMD_SLOT: begin
          if (phase == PH_SENDING) begin
            res_next.tx_valid = 1'b1;
            if (send_index == '0) begin
              res_next.tx_byte = SYM_SOH;
            end else if (send_index == IDX_W'(1)) begin
              res_next.tx_byte = block_number;
            end else if (send_index == IDX_W'(2)) begin
              res_next.tx_byte = ~block_number;
            end else if (send_index < IDX_CHECK_HI) begin
              res_next.tx_byte = data_byte;
              crc_acc_next     = crc16_byte(crc_acc, data_byte);
              sum_acc_next     = sum_acc + data_byte;
            end else if (send_index == IDX_CHECK_HI) begin
              res_next.tx_byte = crc_mode ? crc_acc[15:8] : sum_acc;
            end else begin
              res_next.tx_byte = crc_acc[7:0];
            end
            if (send_index >= last_index) begin
              phase_next = PH_AWAIT;
            end else begin
              send_index_next = send_index + 1'b1;
            end
          end else if (phase == PH_EOT_SEND) begin
            res_next.tx_valid = 1'b1;
            res_next.tx_byte  = SYM_EOT;
            phase_next        = PH_EOT_WAIT;
          end
        end
        default: begin
        end
      endcase
    end

    accepting_next = ((phase_next == PH_HANDSHAKE) || (phase_next == PH_LOADING)) &&
                     (fill_count_next < FILL_FULL) && !source_ended_next;
    res_next.ready_for_data = accepting_next;

    unique case (phase_next)
      PH_HANDSHAKE:            res_next.status = ST_HANDSHAKE;
      PH_LOADING:              res_next.status = ST_LOADING;
      PH_SENDING, PH_EOT_SEND: res_next.status = ST_SENDING;
      PH_AWAIT, PH_EOT_WAIT:   res_next.status = ST_AWAIT;
      PH_DONE:                 res_next.status = ST_DONE;
      default:                 res_next.status = ST_FAILED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HANDSHAKE;
      crc_mode        <= 1'b0;
      block_number    <= BLKNUM_RESET;
      fill_count      <= '0;
      send_index      <= '0;
      crc_acc         <= '0;
      sum_acc         <= '0;
      tries_seen      <= '0;
      source_ended    <= 1'b0;
      handshake_limit <= LIMIT_RESET;
      pad_value       <= PAD_RESET;
      out_valid       <= 1'b0;
    end else begin
      phase        <= phase_next;
      crc_mode     <= crc_mode_next;
      block_number <= block_number_next;
      fill_count   <= fill_count_next;
      send_index   <= send_index_next;
      crc_acc      <= crc_acc_next;
      sum_acc      <= sum_acc_next;
      tries_seen   <= tries_seen_next;
      source_ended <= source_ended_next;
      if (cfg.we) begin
        unique case (cfg.index)
          REG_HANDSHAKE_LIMIT: handshake_limit <= cfg.data[LIMIT_W-1:0];
          REG_PAD_VALUE:       pad_value       <= cfg.data;
          default: begin
          end
        endcase
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= res_next;
    end
  end

  assign results.valid          = out_valid;
  assign results.tx_valid       = out_res.tx_valid;
  assign results.tx_byte        = out_res.tx_byte;
  assign results.ready_for_data = out_res.ready_for_data;
  assign results.status         = out_res.status;

endmodule
`default_nettype wire

// ===== rtl/xmodem_block_sender_core.sv =====
// XMODEM block sender.
// Items enter on the items channel (valid/ready): command 0 is a source byte,
// 1 marks the end of the source, 2 is a byte received from the link and 3 is
// a transmit slot. Every item yields exactly one result on the results channel:
// the byte sent in that slot (tx_valid, tx_byte), whether the block buffer
// still takes source bytes, and the status after the item.
// An accepted item is queued; its result is registered as the item leaves
// the queue head with the output free. Throughput is one item per cycle while
// results are taken: the back end executes one queued item per cycle, set by
// its byte-wide CRC-16 update and the registered read of the 128-byte block
// buffer, which is addressed ahead. A four-entry queue sits between the
// classifying front end and the back end, and the result register frees the
// back end whenever the receiver takes it. When the receiver stalls, the
// result holds, the back end stops, and ready falls once four items are queued.
// Configuration writes (index 0 handshake limit, index 1 pad byte) take
// effect on the next edge and belong in idle periods.
// Reset is synchronous and active high; it empties the queue, drops the
// result, returns to the handshake wait and restores both registers to their
// default values. The buffer needs no clearing pass.
`default_nettype none
module xmodem_block_sender_core import xbs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  xbs_in_if.sink                     items,
  xbs_out_if.source                  results,
  input  wire logic                  write_enable,
  input  wire logic [CFG_IDX_W-1:0]  reg_index,
  input  wire logic [CFG_DATA_W-1:0] write_data
);

  head_t head;
  logic  pop;
  cfg_t  cfg;

  // Configuration write bundled for the back end, which owns the registers.
  assign cfg.we    = write_enable;
  assign cfg.index = reg_index;
  assign cfg.data  = write_data;

  // Front end: accepts items, classifies received bytes and queues them.
  xbs_front u_front (
    .clk   (clk),
    .rst   (rst),
    .items (items),
    .pop   (pop),
    .head  (head)
  );

  // Back end: protocol state, block buffer, check computation and result.
  xbs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule
`default_nettype wire

// ===== rtl/xbs_checker.sv =====
`default_nettype none
`include "xmodem_block_sender_core_macros.svh"
module xbs_checker import xbs_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              tx_valid,
  input wire logic [BYTE_W-1:0] tx_byte,
  input wire logic              ready_for_data,
  input wire logic [2:0]        status
);

  // Reset leaves the queue empty and no result pending.
  `XBS_ASSERT_ALWAYS(a_reset_clears, rst |=> (in_ready && !out_valid), "reset did not clear")

  `XBS_ASSERT(a_result_holds, (out_valid && !out_ready) |=> (out_valid && $stable(tx_byte) && $stable(status)), "stalled result changed")

  // A slot that sends nothing shows a zero byte.
  `XBS_ASSERT(a_idle_byte_zero, (out_valid && !tx_valid) |-> (tx_byte == '0), "idle slot byte not zero")

  // Sending a byte leaves the block sending or waiting for a reply.
  `XBS_ASSERT(a_tx_status, (out_valid && tx_valid) |-> (status == ST_SENDING || status == ST_AWAIT), "byte sent in wrong status")

  `XBS_ASSERT(a_ready_status, (out_valid && ready_for_data) |-> (status == ST_HANDSHAKE || status == ST_LOADING), "buffer open in wrong status")

endmodule

bind xmodem_block_sender_core xbs_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (items.ready),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .tx_valid       (results.tx_valid),
  .tx_byte        (results.tx_byte),
  .ready_for_data (results.ready_for_data),
  .status         (results.status)
);
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

// Verification of the XMODEM block sender: a single link session is driven
// from the handshake through a handful of blocks to the final EOT exchange.
// Every accepted item is fed to a behavioral copy of the sender held in the
// scoreboard, and every result the block returns is compared field by field
// with the oldest prediction.
module testbench;
  import xbs_pkg::*;

  // Cycles in which no item moves on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 1000;
  // Acknowledged blocks before the session is closed.
  localparam int BLOCKS_TO_SEND = 4;
  // Acknowledged blocks between two register settings.
  localparam int CFG_EVERY_BLOCKS = 1;
  localparam int HOLD_CYCLES    = 64;
  localparam int HOLD_AT_RESULT = 400;
  localparam int TAIL_ITEMS     = 8;
  localparam int IDLE_PERCENT   = 30;

  // How the session is closed. Done and failed are both final until reset, and
  // reset happens only once, so each run picks one of these at random.
  typedef enum {END_SHORT, END_EMPTY, END_CANCEL} ending_t;

  // Behavioral copy of the sender plus the results it still owes.
  class link_scoreboard;
    logic [LIMIT_W-1:0] limit;
    logic [BYTE_W-1:0]  pad;
    phase_t             phase;
    bit                 crc_mode;
    logic [BYTE_W-1:0]  blk_num;
    logic [BYTE_W-1:0]  held_bytes [BLOCK_BYTES];
    int                 fill;
    int                 send_pos;
    logic [15:0]        crc;
    logic [BYTE_W-1:0]  sum;
    logic [LIMIT_W-1:0] tries;
    bit                 src_end;
    result_t            pending_tx_results [$];
    int                 errors;
    int                 results_matched;
    int                 blocks_acked;
    int                 resends;
    int                 eots_sent;

    function new();
      limit = LIMIT_RESET;
      pad = PAD_RESET;
      phase = PH_HANDSHAKE;
      crc_mode = 1'b0;
      blk_num = BLKNUM_RESET;
      fill = 0;
      send_pos = 0;
      crc = '0;
      sum = '0;
      tries = '0;
      src_end = 1'b0;
      errors = 0;
      results_matched = 0;
      blocks_acked = 0;
      resends = 0;
      eots_sent = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_HANDSHAKE_LIMIT: limit = data[LIMIT_W-1:0];
        REG_PAD_VALUE: pad = data;
        default: ;
      endcase
    endfunction

    function bit takes_source();
      return (phase == PH_HANDSHAKE || phase == PH_LOADING) && fill < BLOCK_BYTES && !src_end;
    endfunction

    function void start_block();
      send_pos = 0;
      crc = '0;
      sum = '0;
      phase = PH_SENDING;
    endfunction

    function void after_load();
      if (fill >= BLOCK_BYTES) begin
        start_block();
      end else if (src_end) begin
        if (fill > 0) begin
          start_block();
        end else begin
          phase = PH_EOT_SEND;
        end
      end else begin
        phase = PH_LOADING;
      end
    endfunction

    // Bit-serial CRC-16 with polynomial 0x1021, most significant bit first.
    function logic [15:0] crc16_step(logic [15:0] c, logic [BYTE_W-1:0] b);
      logic fb;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c = {c[14:0], 1'b0};
        if (fb) begin
          c = c ^ CRC_POLY;
        end
      end
      return c;
    endfunction

    function logic [BYTE_W-1:0] next_frame_byte();
      logic [BYTE_W-1:0] b;
      int last_pos;
      last_pos = crc_mode ? BLOCK_BYTES + 4 : BLOCK_BYTES + 3;
      if (send_pos == 0) begin
        b = SYM_SOH;
      end else if (send_pos == 1) begin
        b = blk_num;
      end else if (send_pos == 2) begin
        b = ~blk_num;
      end else if (send_pos < BLOCK_BYTES + 3) begin
        b = (send_pos - 3 < fill) ? held_bytes[send_pos - 3] : pad;
        crc = crc16_step(crc, b);
        sum = sum + b;
      end else if (send_pos == BLOCK_BYTES + 3) begin
        b = crc_mode ? crc[15:8] : sum;
      end else begin
        b = crc[7:0];
      end
      if (send_pos >= last_pos) begin
        phase = PH_AWAIT;
      end else begin
        send_pos++;
      end
      return b;
    endfunction

    function status_t status_now();
      case (phase)
        PH_HANDSHAKE: return ST_HANDSHAKE;
        PH_LOADING: return ST_LOADING;
        PH_SENDING, PH_EOT_SEND: return ST_SENDING;
        PH_AWAIT, PH_EOT_WAIT: return ST_AWAIT;
        PH_DONE: return ST_DONE;
        default: return ST_FAILED;
      endcase
    endfunction

    // Advances the copy by one accepted item and queues the result it owes.
    function void take_item(cmd_t cmd, logic [BYTE_W-1:0] v);
      result_t r;
      r = '0;
      case (cmd)
        CMD_SOURCE: begin
          if (takes_source()) begin
            held_bytes[fill] = v;
            fill++;
            if (phase == PH_LOADING && fill >= BLOCK_BYTES) begin
              start_block();
            end
          end
        end
        CMD_END: begin
          if (!src_end) begin
            src_end = 1'b1;
            if (phase == PH_LOADING) begin
              after_load();
            end
          end
        end
        CMD_RECEIVE: begin
          case (phase)
            PH_HANDSHAKE: begin
              if (v == SYM_CRC_REQ) begin
                crc_mode = 1'b1;
                after_load();
              end else if (v == SYM_NAK) begin
                crc_mode = 1'b0;
                after_load();
              end else begin
                tries = tries + 1'b1;
                if (tries >= limit) begin
                  phase = PH_FAILED;
                end
              end
            end
            PH_AWAIT: begin
              if (v == SYM_ACK) begin
                blk_num = blk_num + 1'b1;
                blocks_acked++;
                fill = 0;
                phase = src_end ? PH_EOT_SEND : PH_LOADING;
              end else if (v == SYM_NAK) begin
                resends++;
                start_block();
              end else if (v == SYM_CAN) begin
                phase = PH_FAILED;
              end
            end
            PH_EOT_WAIT: begin
              phase = (v == SYM_ACK) ? PH_DONE : PH_EOT_SEND;
            end
            default: ;
          endcase
        end
        default: begin
          if (phase == PH_SENDING) begin
            r.tx_valid = 1'b1;
            r.tx_byte = next_frame_byte();
          end else if (phase == PH_EOT_SEND) begin
            r.tx_valid = 1'b1;
            r.tx_byte = SYM_EOT;
            phase = PH_EOT_WAIT;
            eots_sent++;
          end
        end
      endcase
      r.ready_for_data = takes_source();
      r.status = status_now();
      pending_tx_results.push_back(r);
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (pending_tx_results.size() == 0) begin
        $error("Result with no item waiting: tx_valid %0d tx_byte 0x%02h status %0d",
               got.tx_valid, got.tx_byte, got.status);
        errors++;
        return;
      end
      want = pending_tx_results.pop_front();
      results_matched++;
      if (got.tx_valid !== want.tx_valid) begin
        $error("tx_valid: expected %0d, actual %0d", want.tx_valid, got.tx_valid);
        errors++;
      end
      if (got.tx_byte !== want.tx_byte) begin
        $error("tx_byte: expected 0x%02h, actual 0x%02h", want.tx_byte, got.tx_byte);
        errors++;
      end
      if (got.ready_for_data !== want.ready_for_data) begin
        $error("ready_for_data: expected %0d, actual %0d",
               want.ready_for_data, got.ready_for_data);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  write_enable;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] write_data;

  xbs_in_if  items_ch ();
  xbs_out_if results_ch ();

  xmodem_block_sender_core u_top (
    .clk          (clk),
    .rst          (rst),
    .items        (items_ch),
    .results      (results_ch),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

  link_scoreboard sb;
  int      items_sent = 0;
  int      settings_applied = 0;
  int      idle_cycles = 0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;
  bit      crc_wanted;
  ending_t ending;
  int      short_fill;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // Result side. The receiver stalls about 30 percent of the time, except for a
  // quiet window where it takes every result, and once it holds off for a long
  // stretch so that the internal queue fills and the block stops taking items.
  always @(posedge clk) begin : result_sink
    result_t got;
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else begin
      if (results_ch.valid && results_ch.ready) begin
        got.tx_valid = results_ch.tx_valid;
        got.tx_byte = results_ch.tx_byte;
        got.ready_for_data = results_ch.ready_for_data;
        got.status = status_t'(results_ch.status);
        sb.match_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        results_ch.ready <= 1'b0;
      end else if (!hold_done && sb.results_matched >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        results_ch.ready <= 1'b0;
      end else if (sb.results_matched >= 900 && sb.results_matched < 1200) begin
        results_ch.ready <= 1'b1;
      end else begin
        results_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // The watchdog only counts cycles in which nothing moves on either channel.
  always @(posedge clk) begin
    if (rst || (items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: nothing moved for %0d cycles, %0d results still owed",
               idle_cycles, sb.pending_tx_results.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one item, with random gaps in front of it, and waits until it is
  // taken. Outside the quiet window the sender idles about 30 percent of the time.
  task automatic drive_item(input cmd_t cmd, input logic [BYTE_W-1:0] val);
    while (!(items_sent >= 600 && items_sent < 900) &&
           $urandom_range(99) < IDLE_PERCENT) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid <= 1'b1;
    items_ch.command <= cmd;
    items_ch.value <= val;
    do @(posedge clk); while (!items_ch.ready);
    sb.take_item(cmd, val);
    items_sent++;
  endtask

  // Stops offering and waits until every owed result has come back. Each item
  // yields exactly one result, so the block is idle once the queue is empty.
  task automatic settle();
    items_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_tx_results.size() != 0);
  endtask

  // Writes the limit and then the pad byte; only called while idle.
  task automatic program_registers(input logic [LIMIT_W-1:0] lim,
                                   input logic [BYTE_W-1:0] pad_byte);
    write_enable <= 1'b1;
    reg_index <= REG_HANDSHAKE_LIMIT;
    write_data <= CFG_DATA_W'(lim);
    @(posedge clk);
    reg_index <= REG_PAD_VALUE;
    write_data <= pad_byte;
    @(posedge clk);
    write_enable <= 1'b0;
    sb.set_register(REG_HANDSHAKE_LIMIT, CFG_DATA_W'(lim));
    sb.set_register(REG_PAD_VALUE, pad_byte);
    settings_applied++;
  endtask

  function automatic logic [BYTE_W-1:0] reply_other_than(input logic [BYTE_W-1:0] a,
                                                         input logic [BYTE_W-1:0] b,
                                                         input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] v;
    do v = BYTE_W'($urandom); while (v == a || v == b || v == c);
    return v;
  endfunction

  // Opening of the session. A slot before anything is ready must send nothing,
  // source bytes are buffered while the handshake is still open, and a handful
  // of bytes that are neither a CRC request nor a NAK count as tries but stay
  // below the limit. Then the buffer is either filled completely, with a few
  // surplus bytes that must be dropped, or only partly, before the receiver's
  // request picks CRC-16 or checksum mode for the whole run.
  task automatic open_handshake();
    int fill_goal;
    drive_item(CMD_SLOT, 8'h00);
    drive_item(CMD_SOURCE, 8'h00);
    drive_item(CMD_SOURCE, 8'hFF);
    drive_item(CMD_RECEIVE, 8'h00);
    drive_item(CMD_RECEIVE, 8'hFF);
    drive_item(CMD_RECEIVE, SYM_ACK);
    drive_item(CMD_RECEIVE, SYM_CAN);
    drive_item(CMD_RECEIVE, SYM_EOT);
    drive_item(CMD_RECEIVE, SYM_SOH);
    // A lower-case c is just another try, not a CRC request.
    drive_item(CMD_RECEIVE, 8'h63);
    drive_item(CMD_SLOT, 8'hFF);
    drive_item(CMD_SOURCE, 8'hA5);
    if ($urandom_range(1) == 1) begin
      while (sb.fill < BLOCK_BYTES) begin
        drive_item(CMD_SOURCE, BYTE_W'($urandom));
      end
      repeat (3) drive_item(CMD_SOURCE, BYTE_W'($urandom));
    end else begin
      fill_goal = $urandom_range(4, 100);
      while (sb.fill < fill_goal) begin
        drive_item(CMD_SOURCE, BYTE_W'($urandom));
      end
    end
    drive_item(CMD_RECEIVE, crc_wanted ? SYM_CRC_REQ : SYM_NAK);
  endtask

  // Main body of the session. The next item is chosen from the predicted phase:
  // mostly well-formed traffic (source bytes while loading, slots while sending,
  // ACK after a block) with some noise that the block must ignore or drop, and
  // occasional NAKs that force a block to be sent again. After enough blocks the
  // session is closed the way this run picked, and a few items are offered to
  // the finished block, which must ignore all of them.
  task automatic run_blocks();
    int r;
    int tail;
    int last_cfg_block;
    bit pad_switched;
    tail = 0;
    last_cfg_block = 0;
    pad_switched = 1'b0;
    while (tail < TAIL_ITEMS) begin
      r = $urandom_range(99);
      case (sb.phase)
        PH_LOADING: begin
          // Between blocks the registers regularly get a new setting.
          if (sb.fill == 0 && sb.blocks_acked % CFG_EVERY_BLOCKS == 0 &&
              sb.blocks_acked != last_cfg_block) begin
            last_cfg_block = sb.blocks_acked;
            settle();
            case ((sb.blocks_acked / CFG_EVERY_BLOCKS) % 3)
              0: program_registers('0, BYTE_W'($urandom));
              1: program_registers('1, 8'hFF);
              default: program_registers(LIMIT_W'($urandom_range(1, 14)), 8'h00);
            endcase
          end
          if (sb.blocks_acked >= BLOCKS_TO_SEND &&
              (ending == END_EMPTY || sb.fill >= short_fill)) begin
            drive_item(CMD_END, BYTE_W'($urandom));
          end else if (r < 4) begin
            drive_item(CMD_SLOT, BYTE_W'($urandom));
          end else if (r < 8) begin
            drive_item(CMD_RECEIVE, BYTE_W'($urandom));
          end else begin
            drive_item(CMD_SOURCE, BYTE_W'($urandom));
          end
        end
        PH_SENDING: begin
          // Halfway through the short final block the pad byte changes, so the
          // rest of the padding must follow the new value.
          if (sb.src_end && !pad_switched && sb.send_pos == 64) begin
            pad_switched = 1'b1;
            settle();
            program_registers(LIMIT_W'($urandom_range(1, 15)),
                              ($urandom_range(1) == 1) ? 8'hFF : 8'h00);
          end
          if (r < 3) begin
            drive_item(CMD_SOURCE, BYTE_W'($urandom));
          end else if (r < 5 && sb.src_end) begin
            drive_item(CMD_END, BYTE_W'($urandom));
          end else if (r < 8) begin
            drive_item(CMD_RECEIVE, BYTE_W'($urandom));
          end else begin
            drive_item(CMD_SLOT, BYTE_W'($urandom));
          end
        end
        PH_AWAIT: begin
          if (ending == END_CANCEL && sb.src_end) begin
            drive_item(CMD_RECEIVE, SYM_CAN);
          end else if (r < 4) begin
            drive_item(CMD_RECEIVE, SYM_NAK);
          end else if (r < 8) begin
            drive_item(CMD_RECEIVE, reply_other_than(SYM_ACK, SYM_NAK, SYM_CAN));
          end else if (r < 10) begin
            drive_item(CMD_SLOT, BYTE_W'($urandom));
          end else if (r < 12) begin
            drive_item(CMD_SOURCE, BYTE_W'($urandom));
          end else begin
            drive_item(CMD_RECEIVE, SYM_ACK);
          end
        end
        PH_EOT_SEND: begin
          if (r < 10) begin
            drive_item(CMD_RECEIVE, BYTE_W'($urandom));
          end else if (r < 15) begin
            drive_item(CMD_SOURCE, BYTE_W'($urandom));
          end else begin
            drive_item(CMD_SLOT, BYTE_W'($urandom));
          end
        end
        PH_EOT_WAIT: begin
          // The first EOT is always refused so that it has to be sent again.
          if (sb.eots_sent < 2 || r < 30) begin
            drive_item(CMD_RECEIVE, reply_other_than(SYM_ACK, SYM_ACK, SYM_ACK));
          end else begin
            drive_item(CMD_RECEIVE, SYM_ACK);
          end
        end
        default: begin
          drive_item(cmd_t'($urandom_range(3)), BYTE_W'($urandom));
          tail++;
        end
      endcase
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    items_ch.valid = 1'b0;
    items_ch.command = CMD_SOURCE;
    items_ch.value = '0;
    results_ch.ready = 1'b0;
    write_enable = 1'b0;
    reg_index = REG_HANDSHAKE_LIMIT;
    write_data = '0;
    crc_wanted = ($urandom_range(1) == 1);
    ending = ending_t'($urandom_range(2));
    short_fill = $urandom_range(1, BLOCK_BYTES - 1);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Widest handshake limit and the lowest pad byte to start with.
    program_registers('1, 8'h00);
    open_handshake();
    settle();
    program_registers(4'd1, 8'hFF);
    run_blocks();

    // Drain everything, then keep watching so that any stray result would show.
    settle();
    repeat (8) @(posedge clk);
    if (sb.pending_tx_results.size() != 0) begin
      $error("%0d results never arrived", sb.pending_tx_results.size());
      sb.errors++;
    end

    $display("Ran %0d items in %s mode: %0d blocks acknowledged, %0d sent again, %0d EOTs",
             items_sent, sb.crc_mode ? "CRC-16" : "checksum", sb.blocks_acked,
             sb.resends, sb.eots_sent);
    $display("Closed by %s with status %s after %0d register settings, %0d mismatches",
             ending.name(), sb.status_now().name(), settings_applied, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/xbs_pkg.sv
rtl/xbs_channels.sv
rtl/xbs_ram.sv
rtl/xbs_front.sv
rtl/xbs_back.sv
rtl/xmodem_block_sender_core.sv
rtl/xbs_checker.sv
verif/testbench.sv
